@@ rtl/pmfm_pkg.sv @@
package pmfm_pkg;

	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int SAMPLE_BITS     = 16;
	localparam int AMP_BITS        = SAMPLE_BITS - 1;
	localparam int TSIZE           = 1 << TABLE_ADDR_BITS;
	localparam int ADDR_BITS       = TABLE_ADDR_BITS + 1;
	localparam int INDEX_BITS      = 16;
	localparam int CFG_IDX_BITS    = 2;
	localparam int CFG_DATA_BITS   = 32;
	localparam int MUL_BITS        = 32;
	localparam int PROD_BITS       = 2 * MUL_BITS;
	localparam int A_BITS          = INDEX_BITS + AMP_BITS;
	localparam int INV_BITS        = 38;
	// right shifts of the PM offset and the FM step
	localparam int PM_SHIFT        = SAMPLE_BITS + 47 - PHASE_BITS;
	localparam int FM_SHIFT        = SAMPLE_BITS + 7;

	typedef longint unsigned u64_t;

	localparam u64_t HALFPI_Q30 = 64'd1686629713;
	localparam u64_t ONE_Q30    = 64'd1 << 30;
	localparam u64_t AMP        = (64'd1 << AMP_BITS) - 64'd1;

	// 1/(2*pi) in Q40
	localparam logic [INV_BITS-1:0] INV2PI_Q40 = 38'd174992710548;

	typedef logic [PHASE_BITS-1:0] phase_t;
	typedef logic [AMP_BITS-1:0]   mag_t;
	typedef mag_t                  qtab_t [0:TSIZE];

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CARRIER_INC = 2'd0,
		REG_MOD_INC     = 2'd1,
		REG_MOD_INDEX   = 2'd2,
		REG_MODE        = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic                 neg;
	} lookup_t;

	localparam u64_t TAYLOR_DIV [0:5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

	// quarter-wave table, Taylor series to x^13 in Q30, rounded to the amplitude
	function automatic qtab_t build_qtab();
		qtab_t   t;
		u64_t    x;
		u64_t    term;
		longint  sum;
		for (int k = 0; k <= TSIZE; k++) begin
			x    = (HALFPI_Q30 * u64_t'(k)) >> TABLE_ADDR_BITS;
			term = x;
			sum  = longint'(x);
			for (int n = 1; n <= 6; n++) begin
				term = ((((term * x) >> 30) * x) >> 30) / TAYLOR_DIV[n-1];
				if (n % 2 == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			if (sum > longint'(ONE_Q30))
				sum = longint'(ONE_Q30);
			t[k] = mag_t'(((u64_t'(sum) * AMP) + (ONE_Q30 >> 1)) >> 30);
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	// quadrant fold; cos_sel adds a quarter turn
	function automatic lookup_t tab_lookup(input phase_t ph, input logic cos_sel);
		logic [1:0]                 quad;
		logic [TABLE_ADDR_BITS-1:0] a;
		lookup_t                    r;
		quad   = ph[PHASE_BITS-1 -: 2] + {1'b0, cos_sel};
		a      = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
		r.addr = quad[0] ? (ADDR_BITS'(TSIZE) - {1'b0, a}) : {1'b0, a};
		r.neg  = quad[1];
		return r;
	endfunction

endpackage

@@ rtl/pm_fm_tone_synthesizer.sv @@
// Two-operator PM / FM tone generator, one audio sample per tick request.
// Request channel: req_valid / req_stall with payload tick. A request with
// tick high makes one sample; a request with tick low is taken and dropped.
// Sample channel: smp_valid / smp_stall with payload sample, signed Q1.15.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 carrier increment, 1 modulator increment, 2 index Q8.8, 3 mode);
// write only while no request is in flight.
// Each sample runs these steps in order: the accept, one quarter-wave
// ROM read, three passes through the shared 32x32 multiplier, an offset
// add, a phase add and fold, a second ROM read and the output load. The
// multiplier and the single ROM port keep the steps in sequence.
// req_stall is high from the cycle after a tick request until the sample
// has been loaded into the output register.
// If the receiver stalls, the sample holds and the next request is still
// taken; its result waits in the last step until the output register frees.
// Reset zeroes the phase and config registers and empties the output.
module pm_fm_tone_synthesizer (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    req_valid,
	output logic                                    req_stall,
	input  logic                                    tick,
	output logic                                    smp_valid,
	input  logic                                    smp_stall,
	output logic signed [pmfm_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                    cfg_we,
	input  logic [pmfm_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [pmfm_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	// one-hot sequencer
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_ROM1 = 9'b000000010,
		ST_MUL1 = 9'b000000100,
		ST_MUL2 = 9'b000001000,
		ST_MUL3 = 9'b000010000,
		ST_SUM  = 9'b000100000,
		ST_ADDR = 9'b001000000,
		ST_ROM2 = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	pmfm_pkg::phase_t                carrier_inc_q;
	pmfm_pkg::phase_t                mod_inc_q;
	logic [pmfm_pkg::INDEX_BITS-1:0] mod_index_q;
	logic                            mode_q;

	// phase accumulators
	pmfm_pkg::phase_t carrier_q;
	pmfm_pkg::phase_t modph_q;
	pmfm_pkg::phase_t fm_q;

	// datapath
	pmfm_pkg::lookup_t                lk_q;
	pmfm_pkg::mag_t                   rom_q;
	logic                             msign_q;
	logic [pmfm_pkg::PROD_BITS-1:0]   prod_q;
	logic [pmfm_pkg::PROD_BITS-1:0]   p0_q;
	logic [pmfm_pkg::A_BITS-1:0]      a_q;
	pmfm_pkg::phase_t                 off_q;
	pmfm_pkg::phase_t                 sum_q;
	logic [pmfm_pkg::SAMPLE_BITS-1:0] sample_q;
	logic                             smp_valid_q;

	logic                             req_take;
	logic                             out_free;
	logic [pmfm_pkg::MUL_BITS-1:0]    mul_a;
	logic [pmfm_pkg::MUL_BITS-1:0]    mul_b;
	logic [pmfm_pkg::PROD_BITS-1:0]   mul_p;
	pmfm_pkg::phase_t                 off_pm;
	pmfm_pkg::phase_t                 off_fm;
	pmfm_pkg::phase_t                 adj_base;
	pmfm_pkg::phase_t                 adj_phase;

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign out_free  = !smp_valid_q || !smp_stall;
	assign smp_valid = smp_valid_q;
	assign sample    = sample_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL1: begin
				mul_a = pmfm_pkg::MUL_BITS'(mod_index_q);
				mul_b = pmfm_pkg::MUL_BITS'(rom_q);
			end
			ST_MUL2: begin
				mul_a = pmfm_pkg::MUL_BITS'(prod_q[pmfm_pkg::A_BITS-1:0]);
				mul_b = mode_q ? mod_inc_q : pmfm_pkg::INV2PI_Q40[pmfm_pkg::MUL_BITS-1:0];
			end
			ST_MUL3: begin
				mul_a = pmfm_pkg::MUL_BITS'(a_q);
				mul_b = pmfm_pkg::MUL_BITS'(
					pmfm_pkg::INV2PI_Q40[pmfm_pkg::INV_BITS-1:pmfm_pkg::MUL_BITS]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = pmfm_pkg::PROD_BITS'(mul_a) * pmfm_pkg::PROD_BITS'(mul_b);

	// PM: low partial product shifted down plus high partial product realigned
	assign off_pm = p0_q[pmfm_pkg::PM_SHIFT +: pmfm_pkg::PHASE_BITS]
		+ pmfm_pkg::PHASE_BITS'(prod_q << (pmfm_pkg::MUL_BITS - pmfm_pkg::PM_SHIFT));
	assign off_fm = p0_q[pmfm_pkg::FM_SHIFT +: pmfm_pkg::PHASE_BITS];

	assign adj_base  = mode_q ? sum_q : carrier_q;
	assign adj_phase = msign_q ? (adj_base - off_q) : (adj_base + off_q);

	// control, configuration and phase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			carrier_inc_q <= '0;
			mod_inc_q     <= '0;
			mod_index_q   <= '0;
			mode_q        <= 1'b0;
			carrier_q     <= '0;
			modph_q       <= '0;
			fm_q          <= '0;
			smp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pmfm_pkg::REG_CARRIER_INC: carrier_inc_q <= cfg_data[pmfm_pkg::PHASE_BITS-1:0];
					pmfm_pkg::REG_MOD_INC:     mod_inc_q     <= cfg_data[pmfm_pkg::PHASE_BITS-1:0];
					pmfm_pkg::REG_MOD_INDEX:   mod_index_q   <= cfg_data[pmfm_pkg::INDEX_BITS-1:0];
					pmfm_pkg::REG_MODE:        mode_q        <= cfg_data[0];
					default: ;
				endcase
			end
			// a new sample may replace one taken at this very edge
			if (state_q == ST_OUT && out_free)
				smp_valid_q <= 1'b1;
			else if (smp_valid_q && !smp_stall)
				smp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_take && tick)
						state_q <= ST_ROM1;
				end
				ST_ROM1: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ADDR;
				ST_ADDR: begin
					if (mode_q)
						fm_q <= adj_phase;
					state_q <= ST_ROM2;
				end
				ST_ROM2: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						carrier_q   <= carrier_q + carrier_inc_q;
						modph_q     <= modph_q + mod_inc_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rom_q <= pmfm_pkg::QTAB[lk_q.addr];
		case (state_q)
			ST_IDLE: begin
				// sine of the modulator for PM, cosine for FM
				lk_q <= pmfm_pkg::tab_lookup(modph_q, mode_q);
			end
			ST_MUL1: begin
				prod_q  <= mul_p;
				msign_q <= lk_q.neg;
			end
			ST_MUL2: begin
				a_q    <= prod_q[pmfm_pkg::A_BITS-1:0];
				prod_q <= mul_p;
			end
			ST_MUL3: begin
				p0_q   <= prod_q;
				prod_q <= mul_p;
			end
			ST_SUM: begin
				off_q <= mode_q ? off_fm : off_pm;
				sum_q <= fm_q + carrier_inc_q;
			end
			ST_ADDR: begin
				// output is the cosine of the old FM phase or of the offset carrier
				lk_q <= pmfm_pkg::tab_lookup(mode_q ? fm_q : adj_phase, 1'b1);
			end
			ST_OUT: begin
				if (out_free)
					sample_q <= lk_q.neg
						? (pmfm_pkg::SAMPLE_BITS'(0) - {1'b0, rom_q})
						: {1'b0, rom_q};
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/pmfm_checker.sv @@
module pmfm_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    req_valid,
	input logic                                    req_stall,
	input logic                                    tick,
	input logic                                    smp_valid,
	input logic                                    smp_stall,
	input logic signed [pmfm_pkg::SAMPLE_BITS-1:0] sample
);

	logic signed [pmfm_pkg::SAMPLE_BITS-1:0] min_neg;
	assign min_neg = {1'b1, {(pmfm_pkg::SAMPLE_BITS-1){1'b0}}};

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_stall |=> smp_valid)
		else $error("sample valid dropped while stalled");

	a_sample_holds: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_stall |=> $stable(sample))
		else $error("stalled sample changed");

	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && tick |=> req_stall)
		else $error("request taken without going busy");

	a_idle_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !tick && !smp_valid |=> !smp_valid)
		else $error("sample produced from a request with tick low");

	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid |-> sample != min_neg)
		else $error("sample outside symmetric range");

endmodule

bind pm_fm_tone_synthesizer pmfm_checker u_pmfm_checker (.*);

@@ tb/tb_pm_fm_tone_synthesizer.sv @@
module tb_pm_fm_tone_synthesizer;

	// fixed-point constants of the synthesis maths
	localparam longint unsigned HALF_PI_Q30    = 64'd1686629713;
	localparam longint unsigned INV_TWO_PI_Q40 = 64'd174992710548;
	localparam logic [31:0]     QUARTER_TURN   = 32'h4000_0000;
	localparam int              ROM_TOP        = 1024;
	// quiet cycles after the last sample before the registers are rewritten
	localparam int              PIPE_CLEAR     = 24;
	localparam int              DRAIN_LIMIT    = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        tick = 1'b0;
	logic        smp_valid;
	logic        smp_stall = 1'b0;
	logic signed [15:0] sample;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = pmfm_pkg::REG_CARRIER_INC;
	logic [31:0] cfg_data = 32'd0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	pm_fm_tone_synthesizer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.tick      (tick),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ---------------------------------------------------------------
	// Predictor: own copy of registers, accumulators and sine ROM
	// ---------------------------------------------------------------
	int          sine_rom [0:ROM_TOP];
	logic [31:0] car_inc, mod_inc;
	logic [15:0] mod_idx;
	logic        fm_mode;
	logic [31:0] car_ph, mod_ph, fm_ph;

	logic [15:0] pending_samples [$];
	int          mismatches = 0;
	int          ticks_sent = 0;
	int          drops_sent = 0;
	int          settings_used = 0;
	bit          bursts_on = 1'b0;

	// quarter-wave ROM: Taylor series to x^13 in Q30, truncated at each step,
	// clamped to [0, 1.0] and rounded to the 15-bit amplitude
	function automatic void build_sine_rom();
		longint unsigned x, term;
		longint          acc;
		for (int k = 0; k <= ROM_TOP; k++) begin
			x    = (HALF_PI_Q30 * 64'(k)) >> 10;
			term = x;
			acc  = longint'(x);
			for (int n = 1; n <= 6; n++) begin
				term = ((((term * x) >> 30) * x) >> 30) / 64'(2 * n * (2 * n + 1));
				if (n % 2 == 1)
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			if (acc > (64'sd1 << 30))
				acc = 64'sd1 << 30;
			sine_rom[k] = int'((64'(acc) * 64'd32767 + 64'd536870912) >> 30);
		end
	endfunction

	// top two bits pick the quadrant, next ten address the ROM
	function automatic int sine_at(input logic [31:0] ph);
		logic [10:0] a;
		int          v;
		a = {1'b0, ph[29:20]};
		if (ph[30])
			a = 11'd1024 - a;
		v = sine_rom[a];
		return ph[31] ? -v : v;
	endfunction

	function automatic int cosine_at(input logic [31:0] ph);
		return sine_at(ph + QUARTER_TURN);
	endfunction

	// one tick: sample out, then both accumulators (and FM phase) advance
	function automatic logic [15:0] predict_sample();
		int               s, y;
		longint unsigned  mag;
		logic [127:0]     prod;
		logic [31:0]      step, ph;
		if (!fm_mode) begin
			s    = sine_at(mod_ph);
			mag  = (s < 0) ? -s : s;
			prod = 128'(mod_idx) * 128'(mag) * 128'(INV_TWO_PI_Q40);
			step = prod[62:31];
			ph   = (s < 0) ? car_ph - step : car_ph + step;
			y    = cosine_at(ph);
		end else begin
			s    = cosine_at(mod_ph);
			mag  = (s < 0) ? -s : s;
			prod = 128'(mod_idx) * 128'(mag) * 128'(mod_inc);
			step = prod[54:23];
			y    = cosine_at(fm_ph);
			fm_ph = (s < 0) ? fm_ph + car_inc - step : fm_ph + car_inc + step;
		end
		car_ph = car_ph + car_inc;
		mod_ph = mod_ph + mod_inc;
		return y[15:0];
	endfunction

	// ---------------------------------------------------------------
	// Shared tasks
	// ---------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// register write; only called with the block idle
	task automatic write_reg(input pmfm_pkg::cfg_reg_t r, input logic [31:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (r)
			pmfm_pkg::REG_CARRIER_INC: car_inc = v;
			pmfm_pkg::REG_MOD_INC:     mod_inc = v;
			pmfm_pkg::REG_MOD_INDEX:   mod_idx = v[15:0];
			pmfm_pkg::REG_MODE:        fm_mode = v[0];
			default: ;
		endcase
	endtask

	// all four registers; unused upper bits get noise, which must be ignored
	task automatic apply_setting(input logic [31:0] ci, input logic [31:0] mi,
			input logic [15:0] ix, input logic md);
		write_reg(pmfm_pkg::REG_CARRIER_INC, ci);
		write_reg(pmfm_pkg::REG_MOD_INC, mi);
		write_reg(pmfm_pkg::REG_MOD_INDEX, {16'($urandom), ix});
		write_reg(pmfm_pkg::REG_MODE, {31'($urandom), md});
		settings_used++;
	endtask

	// one request; valid held until the block takes it
	task automatic send_request(input logic t);
		@(negedge clk);
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		req_valid <= 1'b1;
		tick      <= t;
		do @(posedge clk); while (req_stall !== 1'b0);
		if (t) begin
			pending_samples.push_back(predict_sample());
			ticks_sent++;
		end else
			drops_sent++;
	endtask

	// drop valid, wait for every sample, then let dropped requests clear
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_samples.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (pending_samples.size() != 0) begin
			report_mismatch($sformatf("%0d samples never arrived",
				pending_samples.size()));
			pending_samples.delete();
		end
		repeat (PIPE_CLEAR) @(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// Sample side: random stall bursts and the checker
	// ---------------------------------------------------------------
	always begin
		@(negedge clk);
		if (bursts_on && $urandom_range(0, 5) == 0) begin
			smp_stall <= 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			smp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && smp_valid === 1'b1 && smp_stall == 1'b0) begin
			if (pending_samples.size() == 0)
				report_mismatch($sformatf("unexpected sample %0d", sample));
			else if (sample !== $signed(pending_samples[0])) begin
				report_mismatch($sformatf("sample %0d, expected %0d", sample,
					$signed(pending_samples[0])));
				void'(pending_samples.pop_front());
			end else
				void'(pending_samples.pop_front());
		end
	end

	// ---------------------------------------------------------------
	// Random register picks, weighted towards the extremes
	// ---------------------------------------------------------------
	function automatic logic [31:0] pick_increment();
		case ($urandom_range(0, 5))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2:       return $urandom_range(0, 32'h00FF_FFFF);  // audio-like pitch
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_index();
		case ($urandom_range(0, 4))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(0, 16'h0800));  // up to 8 rad
			default: return 16'($urandom);
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// all registers zero: the output sits at cos(0); a tick-low request is
	// taken and gives nothing
	task automatic test_after_reset();
		send_request(1'b1);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b1);
		settle();
	endtask

	// PM: quarter-turn carrier walks the quadrants, then the deepest index
	task automatic test_pm_directed();
		apply_setting(QUARTER_TURN, 32'd0, 16'd0, 1'b0);
		repeat (4) send_request(1'b1);
		settle();
		apply_setting(32'hFFFF_FFFF, QUARTER_TURN, 16'hFFFF, 1'b0);
		repeat (4) send_request(1'b1);
		settle();
	endtask

	// FM: the largest step product, then a modest tone with a dropped request
	task automatic test_fm_directed();
		apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		repeat (5) send_request(1'b1);
		settle();
		apply_setting(32'h0100_0000, 32'h0080_0000, 16'h0280, 1'b1);
		send_request(1'b1);
		send_request(1'b0);
		repeat (3) send_request(1'b1);
		settle();
	endtask

	// random settings, each followed by a run of requests, mostly ticks
	task automatic test_random_settings(input int target);
		int stop_at;
		int run;
		stop_at = ticks_sent + target;
		while (ticks_sent < stop_at) begin
			bursts_on = ($urandom_range(0, 4) != 0);
			apply_setting(pick_increment(), pick_increment(), pick_index(),
				1'($urandom_range(0, 1)));
			run = $urandom_range(20, 120);
			repeat (run) send_request($urandom_range(0, 9) != 0);
			settle();
		end
	endtask

	// closing stretch at full rate: no gaps on either side
	task automatic test_back_to_back(input int target);
		int stop_at;
		bursts_on = 1'b0;
		stop_at = ticks_sent + target;
		while (ticks_sent < stop_at) begin
			apply_setting(pick_increment(), pick_increment(), pick_index(),
				1'($urandom_range(0, 1)));
			repeat ($urandom_range(30, 80)) send_request($urandom_range(0, 15) != 0);
			settle();
		end
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		build_sine_rom();
		car_inc = '0;
		mod_inc = '0;
		mod_idx = '0;
		fm_mode = 1'b0;
		car_ph  = '0;
		mod_ph  = '0;
		fm_ph   = '0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_pm_directed();
		test_fm_directed();
		test_random_settings(1350);
		test_back_to_back(200);

		repeat (40) @(negedge clk);
		$display("covered %0d samples and %0d dropped requests over %0d register settings",
			ticks_sent, drops_sent, settings_used);
		$display("both PM and FM modes, with and without stall bursts on either side");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#8000000;
		$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/pmfm_pkg.sv
rtl/pm_fm_tone_synthesizer.sv
rtl/pmfm_checker.sv
tb/tb_pm_fm_tone_synthesizer.sv
